@@ hdl/bba_pkg.sv @@
// Shared definitions for the block bitmap allocator: field widths, request modes,
// status codes and reset values.
// No dependencies; every other file of the block but bba_ram.sv uses it.
`default_nettype none

package bba_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 4096;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned POS_W  = 13;
	localparam int unsigned IDX_W  = 12;
	localparam int unsigned ST_W   = 2;
	localparam int unsigned BYTE_W = 8;

	// Block 0 of a byte sits in its most significant bit.
	localparam logic [2:0] BIT_TOP = 3'd7;

	localparam logic [POS_W-1:0] BITS_RESET = POS_W'(4096);

	typedef enum logic [MODE_W-1:0] {
		MODE_SET  = 2'd0,
		MODE_FIND = 2'd1,
		MODE_INIT = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ hdl/bba_if.sv @@
// Request and response channel interfaces of the block bitmap allocator.
// Depends on bba_pkg for the field widths.
`default_nettype none

interface bba_req_if;
	logic                          valid;
	logic                          ready;
	logic [bba_pkg::MODE_W-1:0]    mode;
	logic [bba_pkg::POS_W-1:0]     position;
	logic                          bit_value;

	modport source (output valid, output mode, output position, output bit_value, input ready);
	modport sink   (input valid, input mode, input position, input bit_value, output ready);
endinterface

interface bba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bba_pkg::IDX_W-1:0]     block_index;
	logic [bba_pkg::ST_W-1:0]      status_code;

	modport source (output valid, output block_index, output status_code, input ready);
	modport sink   (input valid, input block_index, input status_code, output ready);
endinterface

`default_nettype wire

@@ hdl/bba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/block_bitmap_allocator_top.sv @@
// Set reads its bitmap byte and writes it back; find reads bytes up to a hit or the last;
// initialize rewrites ceil(limit/8) bytes; range errors and the undefined mode skip the RAM.
// Throughput: one request at a time, one bitmap byte per cycle through the RAM read port;
// a finished response may wait in the output register while the next request is taken.
// Reset: arst_n clears control state and sets bits_in_use to 4096, then a clearing pass
// writes zeros to all ceil(MAX_BLOCKS/8) bitmap bytes before any request.
`default_nettype none

module block_bitmap_allocator_top #(
	parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bba_pkg::POS_W-1:0]   cfg_wdata,
	bba_req_if.sink                          req,
	bba_rsp_if.source                        rsp
);

	localparam int unsigned PW     = bba_pkg::POS_W;
	localparam int unsigned XW     = bba_pkg::IDX_W;
	localparam int unsigned BW     = bba_pkg::BYTE_W;
	localparam int unsigned DEPTH  = (MAX_BLOCKS + BW - 1) / BW;
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// The register can never name more than 2^13-1 blocks, so the limit fits in 13 bits.
	localparam int unsigned LIM_CAP = (MAX_BLOCKS > (2 ** PW) - 1) ? (2 ** PW) - 1 : MAX_BLOCKS;
	localparam logic [PW-1:0] LIM_CAP_V = PW'(LIM_CAP);
	localparam logic [AW-1:0] LAST_ROW  = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SET_RD,
		S_SET_WR,
		S_SCAN,
		S_DONE
	} state_t;

	// Configuration register and the active limit derived from it.
	logic [PW-1:0] bits_q;
	logic [PW-1:0] lim;
	logic [PW-1:0] lim_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= bba_pkg::BITS_RESET;
		end else if (cfg_we) begin
			bits_q <= cfg_wdata;
		end
	end

	assign lim    = (bits_q > LIM_CAP_V) ? LIM_CAP_V : bits_q;
	assign lim_m1 = lim - PW'(1);

	// Control and request context.
	state_t           state_q;
	bba_pkg::mode_t   op_q;
	logic [PW-1:0]    pos_q;
	logic             val_q;
	logic [AW-1:0]    first_q;
	logic [2:0]       start_off_q;
	logic [AW-1:0]    last_q;
	logic [2:0]       last_off_q;
	logic [AW-1:0]    addr_q;
	logic             issue_q;

	// Read stage: the byte address whose data shows on the RAM output.
	logic             rd_v_s1;
	logic [AW-1:0]    rd_addr_s1;

	// Pending result and output register.
	logic [XW-1:0]    res_idx_q;
	bba_pkg::status_t res_st_q;
	logic             out_valid_q;
	logic [XW-1:0]    out_idx_q;
	bba_pkg::status_t out_st_q;

	// RAM port signals.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [BW-1:0]    ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [BW-1:0]    ram_rdata;

	logic             req_fire;
	logic             out_free;
	bba_pkg::mode_t   req_mode;
	logic [AW-1:0]    req_byte;
	logic             req_range;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign req_mode  = bba_pkg::mode_t'(req.mode);
	assign req_byte  = AW'(req.position[PW-1:3]);
	assign out_free  = !out_valid_q || rsp.ready;
	// Set and find reject a position at or past the limit; the other modes never do.
	assign req_range = (req.position >= lim)
		&& (req_mode == bba_pkg::MODE_SET || req_mode == bba_pkg::MODE_FIND);

	// Byte evaluation for the scan. Bit k of a byte means block 8*addr + k, which is
	// data bit 7-k. Edge bytes are masked to the window between start and limit.
	logic [BW-1:0]    allowed;
	logic [BW-1:0]    match;
	logic [BW-1:0]    init_byte;
	logic [BW-1:0]    set_byte;
	logic             hit;
	logic [2:0]       hit_k;
	logic [PW-1:0]    blk;

	always_comb begin
		hit       = 1'b0;
		hit_k     = '0;
		blk       = '0;
		init_byte = ram_rdata;
		for (int k = BW - 1; k >= 0; k--) begin
			blk = PW'({rd_addr_s1, 3'(k)});
			allowed[k] = !((rd_addr_s1 == first_q) && (3'(k) < start_off_q))
				&& !((rd_addr_s1 == last_q) && (3'(k) > last_off_q));
			match[k] = (ram_rdata[bba_pkg::BIT_TOP - 3'(k)] == val_q) && allowed[k];
			// Initialize keeps the bits of the last byte that lie past the limit.
			if (!((rd_addr_s1 == last_q) && (3'(k) > last_off_q))) begin
				init_byte[bba_pkg::BIT_TOP - 3'(k)] = (blk < pos_q);
			end
			if (match[k]) begin
				hit   = 1'b1;
				hit_k = 3'(k);
			end
		end
	end

	always_comb begin
		set_byte = ram_rdata;
		set_byte[bba_pkg::BIT_TOP - pos_q[2:0]] = val_q;
	end

	// RAM port steering by state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_SET_RD: begin
				ram_re = 1'b1;
			end
			S_SET_WR: begin
				ram_we    = 1'b1;
				ram_wdata = set_byte;
			end
			S_SCAN: begin
				ram_re    = issue_q;
				ram_we    = rd_v_s1 && (op_q == bba_pkg::MODE_INIT);
				ram_waddr = rd_addr_s1;
				ram_wdata = init_byte;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the done state the output register is reloaded whenever it is taken.
			if (rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_ROW) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						op_q        <= req_mode;
						pos_q       <= req.position;
						val_q       <= req.bit_value;
						first_q     <= req_byte;
						start_off_q <= req.position[2:0];
						last_q      <= AW'(lim_m1[PW-1:3]);
						last_off_q  <= lim_m1[2:0];
						res_idx_q   <= '0;
						res_st_q    <= req_range ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
						unique case (req_mode)
							bba_pkg::MODE_SET: begin
								if (req_range) begin
									state_q <= S_DONE;
								end else begin
									addr_q  <= req_byte;
									state_q <= S_SET_RD;
								end
							end
							bba_pkg::MODE_FIND: begin
								if (req_range) begin
									state_q <= S_DONE;
								end else begin
									addr_q  <= req_byte;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							bba_pkg::MODE_INIT: begin
								if (lim == '0) begin
									state_q <= S_DONE;
								end else begin
									addr_q  <= '0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							bba_pkg::MODE_NOP: begin
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SET_RD: begin
					state_q <= S_SET_WR;
				end
				S_SET_WR: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// A hit or the last byte ends the scan; otherwise the next byte read is
					// issued while the previous byte is evaluated.
					if (rd_v_s1 && ((op_q == bba_pkg::MODE_FIND && hit)
							|| rd_addr_s1 == last_q)) begin
						if (op_q == bba_pkg::MODE_FIND && hit) begin
							res_idx_q <= XW'({rd_addr_s1, hit_k});
						end else if (op_q == bba_pkg::MODE_FIND) begin
							res_st_q <= bba_pkg::ST_NOTFOUND;
						end
						issue_q <= 1'b0;
						rd_v_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (issue_q) begin
						rd_v_s1    <= 1'b1;
						rd_addr_s1 <= addr_q;
						if (addr_q == last_q) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + AW'(1);
						end
					end else begin
						rd_v_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.block_index = out_idx_q;
	assign rsp.status_code = out_st_q;

	bba_ram #(
		.WIDTH (BW),
		.DEPTH (DEPTH)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

@@ hdl/bba_checker.sv @@
// Port-level checks of the block bitmap allocator and the bind that attaches them.
// Depends on bba_pkg and on block_bitmap_allocator_top.
`default_nettype none

module bba_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [bba_pkg::IDX_W-1:0] rsp_block_index,
	input wire logic [bba_pkg::ST_W-1:0]  rsp_status_code
);

	// Requests taken whose responses have not yet been taken.
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_index)
			&& $stable(rsp_status_code))
		else $error("response changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status_code == bba_pkg::ST_OK
			|| rsp_status_code == bba_pkg::ST_RANGE
			|| rsp_status_code == bba_pkg::ST_NOTFOUND)
		else $error("undefined status code");

	a_error_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status_code != bba_pkg::ST_OK |-> rsp_block_index == '0)
		else $error("error response carries a block index");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_block_index (rsp.block_index),
	.rsp_status_code (rsp.status_code)
);

`default_nettype wire

@@ dv/block_bitmap_allocator_top_tb.sv @@
// Self-checking testbench for block_bitmap_allocator_top: directed requests from a table,
// then random requests over several bits_in_use settings, scored against a model or the table.
// Depends on bba_pkg, bba_if.sv and the block's RTL.
`default_nettype none

module block_bitmap_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POS_W = bba_pkg::POS_W;
	localparam int unsigned IDX_W = bba_pkg::IDX_W;
	localparam int unsigned BLOCK_COUNT = bba_pkg::MAX_BLOCKS_DEF;
	// The slowest correct run is 420 requests, each of which may scan the whole bitmap,
	// plus the clearing pass after reset. The limit leaves several times that as headroom.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned MISMATCH_SHOWN = 10;
	localparam int unsigned PHASE_COUNT = 10;
	localparam int unsigned REQUESTS_PER_PHASE = 40;

	// One response as the block should send it.
	typedef struct packed {
		logic [IDX_W-1:0] index;
		bba_pkg::status_t status;
	} answer_t;

	// One row of the directed table. A row either writes bits_in_use (cfg_write set,
	// value in position) or sends one request. Where typed is set, the expected
	// response is taken from the row instead of from the model.
	typedef struct {
		bit               cfg_write;
		bba_pkg::mode_t   mode;
		logic [POS_W-1:0] position;
		logic             bit_value;
		bit               typed;
		answer_t          expected;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [POS_W-1:0] cfg_wdata;

	bba_req_if req();
	bba_rsp_if rsp();

	block_bitmap_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// Local copy of the block's state: one entry per block, 1 meaning used.
	bit               block_used [0:BLOCK_COUNT-1];
	logic [POS_W-1:0] bits_in_use_model;

	answer_t   pending_answers[$];
	stim_row_t directed_rows[$];

	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned burst_left;

	// The random part walks through these settings, including zero, the largest
	// value the register can hold and the parameter itself.
	int unsigned phase_bits [PHASE_COUNT] = '{37, 8191, 0, 9, 4096, 1, 300, 8, 4095, 64};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Works out the response to one request and updates the model's bitmap the way
	// the block updates its own. Only blocks below the active limit are touched.
	function automatic void predict_answer(input bba_pkg::mode_t m,
			input logic [POS_W-1:0] pos, input logic v, output answer_t ans);
		int unsigned lim;
		int unsigned blk;
		lim = (bits_in_use_model > BLOCK_COUNT) ? BLOCK_COUNT : bits_in_use_model;
		ans.index = '0;
		ans.status = bba_pkg::ST_OK;
		case (m)
			bba_pkg::MODE_SET: begin
				if (pos >= lim)
					ans.status = bba_pkg::ST_RANGE;
				else
					block_used[pos] = v;
			end
			bba_pkg::MODE_FIND: begin
				if (pos >= lim) begin
					ans.status = bba_pkg::ST_RANGE;
				end else begin
					ans.status = bba_pkg::ST_NOTFOUND;
					for (blk = pos; blk < lim; blk++) begin
						if (block_used[blk] == v) begin
							ans.status = bba_pkg::ST_OK;
							ans.index = blk[IDX_W-1:0];
							break;
						end
					end
				end
			end
			bba_pkg::MODE_INIT: begin
				for (blk = 0; blk < lim; blk++)
					block_used[blk] = (blk < pos);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void plan_request(input bba_pkg::mode_t m, input logic [POS_W-1:0] pos,
			input logic v, input bit typed, input logic [IDX_W-1:0] idx,
			input bba_pkg::status_t st);
		stim_row_t r;
		r.cfg_write = 1'b0;
		r.mode = m;
		r.position = pos;
		r.bit_value = v;
		r.typed = typed;
		r.expected.index = idx;
		r.expected.status = st;
		directed_rows.push_back(r);
	endfunction

	function automatic void plan_cfg(input logic [POS_W-1:0] value);
		stim_row_t r;
		r.cfg_write = 1'b1;
		r.mode = bba_pkg::MODE_NOP;
		r.position = value;
		r.bit_value = 1'b0;
		r.typed = 1'b0;
		r.expected = '0;
		directed_rows.push_back(r);
	endfunction

	// Presents one request and holds it until the block takes it. The expectation is
	// queued at the edge of acceptance, so the model sees requests in the block's order.
	// valid is left high; the caller either sends the next request at once or lowers it.
	task automatic send_request(input bba_pkg::mode_t m, input logic [POS_W-1:0] pos,
			input logic v, input bit typed, input answer_t typed_ans);
		answer_t ans;
		req.valid <= 1'b1;
		req.mode <= m;
		req.position <= pos;
		req.bit_value <= v;
		do @(posedge clk); while (req.ready !== 1'b1);
		predict_answer(m, pos, v, ans);
		pending_answers.push_back(typed ? typed_ans : ans);
	endtask

	// The sender works in bursts: back-to-back requests, then a gap of a few cycles.
	// Now and then a burst is long, so that stretches with no idling occur too.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
		end
	endtask

	// Stops sending until every outstanding request has been answered.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only while the block is idle. Every request answers, so once
	// the queue is empty the block holds no work; a few spare cycles follow anyway.
	task automatic write_bits_in_use(input logic [POS_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bits_in_use_model = value;
	endtask

	// Receiver: ready follows an 8-bit pattern that rotates every cycle and is reloaded when
	// pattern_age wraps. Some patterns are all ones, so there are stretches with no stall.
	// Responses are sampled at the edge, with the values that held just before it.
	initial begin
		logic [7:0]  ready_pattern;
		int unsigned pattern_age;
		answer_t     want;
		ready_pattern = 8'hFF;
		pattern_age = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MISMATCH_SHOWN)
						$display("[%0t] response with no request: index %0d status %0d",
							$realtime, rsp.block_index, rsp.status_code);
				end else begin
					want = pending_answers.pop_front();
					if (rsp.block_index !== want.index || rsp.status_code !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= MISMATCH_SHOWN)
							$display("[%0t] expected index %0d status %0d, got %0d %0d",
								$realtime, want.index, want.status, rsp.block_index,
								rsp.status_code);
					end
				end
			end
			if (pattern_age == 50) begin
				pattern_age = 0;
				case ($urandom_range(0, 3))
					0, 1: ready_pattern = 8'hFF;
					default: ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
				endcase
			end else begin
				pattern_age++;
			end
			rsp.ready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
		end
	end

	// Watchdog: a run that outlives the limit has hung somewhere.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		stim_row_t        row;
		answer_t          typed_ans;
		bba_pkg::mode_t   m;
		logic [POS_W-1:0] pos;
		logic             v;
		int unsigned      lim;
		int unsigned      anchor;
		int unsigned      pick;
		int unsigned      phase;
		int unsigned      n;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.mode <= bba_pkg::MODE_NOP;
		req.position <= '0;
		req.bit_value <= 1'b0;
		mismatch_count = 0;
		burst_left = 0;
		anchor = 0;
		bits_in_use_model = bba_pkg::BITS_RESET;
		foreach (block_used[i])
			block_used[i] = 1'b0;

		// Directed table. After reset the bitmap is all free and bits_in_use is 4096.
		plan_request(bba_pkg::MODE_FIND, 13'd0,    1'b0, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd4095, 1'b1, 1'b1, 12'd0, bba_pkg::ST_NOTFOUND);
		plan_request(bba_pkg::MODE_FIND, 13'd4096, 1'b0, 1'b1, 12'd0, bba_pkg::ST_RANGE);
		plan_request(bba_pkg::MODE_SET,  13'd8191, 1'b1, 1'b1, 12'd0, bba_pkg::ST_RANGE);
		plan_request(bba_pkg::MODE_SET,  13'd0,    1'b1, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_SET,  13'd4095, 1'b1, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd1,    1'b1, 1'b0, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd0,    1'b1, 1'b0, 12'd0, bba_pkg::ST_OK);
		// The undefined mode does nothing and answers zero.
		plan_request(bba_pkg::MODE_NOP,  13'd5461, 1'b1, 1'b1, 12'd0, bba_pkg::ST_OK);
		// A reserved count above the limit marks every active block used.
		plan_request(bba_pkg::MODE_INIT, 13'd8191, 1'b0, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd0,    1'b0, 1'b0, 12'd0, bba_pkg::ST_OK);
		// With a small limit, initialize must leave the blocks above it alone.
		plan_cfg(13'd20);
		plan_request(bba_pkg::MODE_INIT, 13'd5,    1'b1, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_SET,  13'd20,   1'b0, 1'b1, 12'd0, bba_pkg::ST_RANGE);
		plan_request(bba_pkg::MODE_FIND, 13'd19,   1'b1, 1'b0, 12'd0, bba_pkg::ST_OK);
		// A register value above the block count acts as the block count.
		plan_cfg(13'd8191);
		plan_request(bba_pkg::MODE_FIND, 13'd20,   1'b1, 1'b0, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_SET,  13'd4095, 1'b0, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd4095, 1'b1, 1'b0, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd4096, 1'b1, 1'b1, 12'd0, bba_pkg::ST_RANGE);
		plan_request(bba_pkg::MODE_INIT, 13'd0,    1'b0, 1'b1, 12'd0, bba_pkg::ST_OK);
		plan_request(bba_pkg::MODE_FIND, 13'd3,    1'b0, 1'b0, 12'd0, bba_pkg::ST_OK);
		plan_cfg(13'd4096);

		// After reset the block clears its bitmap before it takes the first request; the
		// handshake simply waits that out.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg_write) begin
				write_bits_in_use(row.position);
			end else begin
				send_request(row.mode, row.position, row.bit_value, row.typed, row.expected);
				pace_sender();
			end
		end

		// Random part. Each phase sets bits_in_use and then mixes sets, finds, the occasional
		// initialize and rare undefined-mode requests. Finds often start just below the last
		// block written, so that searches land on blocks that have actually been changed.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			write_bits_in_use(POS_W'(phase_bits[phase]));
			lim = (bits_in_use_model > BLOCK_COUNT) ? BLOCK_COUNT : bits_in_use_model;
			for (n = 0; n < REQUESTS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					m = bba_pkg::MODE_SET;
				else if (pick < 82)
					m = bba_pkg::MODE_FIND;
				else if (pick < 95)
					m = bba_pkg::MODE_INIT;
				else
					m = bba_pkg::MODE_NOP;
				case ($urandom_range(0, 9))
					0: pos = POS_W'($urandom_range(0, 8191));
					1: pos = POS_W'(lim + $urandom_range(0, 2));
					2: pos = (lim == 0) ? '0 : POS_W'(lim - 1);
					3, 4, 5: pos = POS_W'((anchor > 16) ? anchor - $urandom_range(0, 16) : 0);
					default: pos = (lim == 0) ? POS_W'($urandom_range(0, 8191))
						: POS_W'($urandom_range(0, lim - 1));
				endcase
				v = 1'($urandom_range(0, 1));
				typed_ans = '0;
				send_request(m, pos, v, 1'b0, typed_ans);
				if (m == bba_pkg::MODE_SET || m == bba_pkg::MODE_INIT)
					anchor = pos;
				// Occasionally hold off until the block has answered everything.
				if ($urandom_range(0, 59) == 0)
					drain();
				pace_sender();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

@@ block_bitmap_allocator_top.f @@
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_ram.sv
hdl/block_bitmap_allocator_top.sv
hdl/bba_checker.sv
dv/block_bitmap_allocator_top_tb.sv
